@@ rtl/pol_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the positional ordered list.
// No dependencies; used by pol_cell and positional_ordered_list.
package pol_pkg;

   // Command codes on req_cmd
   localparam logic [2:0] CMD_INS_POS = 3'd0;
   localparam logic [2:0] CMD_INS_END = 3'd1;
   localparam logic [2:0] CMD_DEL_POS = 3'd2;
   localparam logic [2:0] CMD_DEL_END = 3'd3;
   localparam logic [2:0] CMD_DUMP    = 3'd4;

   // Status codes on rsp_status
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_BOUND   = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam int unsigned DATA_W = 32;

   // What a cell loads on the next edge
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_LOAD  = 3'd1,   // new value from the request
      CELL_LEFT  = 3'd2,   // shift toward the back
      CELL_RIGHT = 3'd3,   // shift toward the front
      CELL_HEAD  = 3'd4    // wrap the front element in during a dump
   } pol_cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DUMP = 2'b10
   } pol_state_type;

endpackage

@@ rtl/positional_ordered_list.sv @@
`timescale 1ns / 1ps
// Positional ordered list: a chain of CAPACITY cells, front at cell 0.
// Insert/delete: result beat registered the cycle after accept. Dump: one result
//   beat per cycle while rsp_ready is high, count beats; the chain rotates once
//   per beat and is back in order after the last one. Next command after that.
// Throughput: one command per cycle for single-result commands while rsp_ready
//   is high, set by the output register. Sync reset empties the list; cells unreset.
module positional_ordered_list #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [4:0]                        req_position,
   input  logic signed [pol_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic signed [pol_pkg::DATA_W-1:0] rsp_element,
   output logic [4:0]                        rsp_length,
   output logic                              rsp_last
);

   localparam int unsigned IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;  // cell index
   localparam int unsigned CW = $clog2(CAPACITY + 1);                    // element count
   localparam int unsigned MW = ((CW > 5) ? CW : 5) + 1;                // compare width

   // control state
   pol_pkg::pol_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          dump_left_ff, dump_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // output beat register
   logic [2:0]                        rsp_status_ff, rsp_status_in;
   logic signed [pol_pkg::DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [4:0]                        rsp_length_ff, rsp_length_in;
   logic                              rsp_last_ff, rsp_last_in;

   // cell chain
   logic signed [pol_pkg::DATA_W-1:0] cell_q [CAPACITY];
   pol_pkg::pol_cell_op_type          cell_op [CAPACITY];

   logic          slot_free;
   logic          accept;
   logic          do_ins, do_del, do_rot;
   logic [IW-1:0] ins_idx, del_idx;
   logic [MW-1:0] pos_ext, cnt_ext;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pol_pkg::FSM_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign pos_ext   = MW'(req_position);
   assign cnt_ext   = MW'(count_ff);

   // Command decode, result beat and next state
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_left_in   = dump_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_last_in    = rsp_last_ff;
      do_ins         = 1'b0;
      do_del         = 1'b0;
      do_rot         = 1'b0;
      ins_idx        = '0;
      del_idx        = '0;

      unique case (state_ff)
         pol_pkg::FSM_IDLE: begin
            if (accept) begin
               // single-result defaults; dump and unknown codes override
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pol_pkg::ST_OK;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               unique case (req_cmd)
                  pol_pkg::CMD_INS_POS: begin
                     if (req_position == 5'd0) begin
                        rsp_status_in = pol_pkg::ST_INVALID;
                     end else if (cnt_ext == MW'(CAPACITY)) begin
                        rsp_status_in = pol_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        do_ins  = 1'b1;  // empty list: any position lands at the front
                        ins_idx = '0;
                     end else if (pos_ext > cnt_ext + MW'(1)) begin
                        rsp_status_in = pol_pkg::ST_BOUND;
                     end else begin
                        do_ins  = 1'b1;
                        ins_idx = IW'(pos_ext - MW'(1));
                     end
                  end
                  pol_pkg::CMD_INS_END: begin
                     if (cnt_ext == MW'(CAPACITY)) begin
                        rsp_status_in = pol_pkg::ST_FULL;
                     end else begin
                        do_ins  = 1'b1;
                        ins_idx = IW'(count_ff);
                     end
                  end
                  pol_pkg::CMD_DEL_POS: begin
                     if (count_ff == '0) begin
                        rsp_status_in = pol_pkg::ST_EMPTY;
                     end else if (req_position == 5'd0) begin
                        rsp_status_in = pol_pkg::ST_INVALID;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_status_in = pol_pkg::ST_BOUND;
                     end else begin
                        do_del  = 1'b1;
                        del_idx = IW'(pos_ext - MW'(1));
                     end
                  end
                  pol_pkg::CMD_DEL_END: begin
                     if (count_ff == '0) begin
                        rsp_status_in = pol_pkg::ST_EMPTY;
                     end else begin
                        do_del  = 1'b1;
                        del_idx = IW'(count_ff - CW'(1));
                     end
                  end
                  pol_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = pol_pkg::ST_EMPTY;
                     end else begin
                        // beats come from the DUMP state
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        state_in     = pol_pkg::FSM_DUMP;
                        dump_left_in = count_ff;
                     end
                  end
                  default: begin
                     // unknown code: swallowed, no beat
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase

               if (do_ins) begin
                  count_in = count_ff + CW'(1);
               end
               if (do_del) begin
                  count_in       = count_ff - CW'(1);
                  rsp_element_in = cell_q[del_idx];
               end
               rsp_length_in = 5'(count_in);
            end
         end
         pol_pkg::FSM_DUMP: begin
            // front element out, chain rotates within the occupied cells
            if (slot_free) begin
               do_rot         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pol_pkg::ST_OK;
               rsp_element_in = cell_q[0];
               rsp_length_in  = 5'(count_ff);
               rsp_last_in    = (dump_left_ff == CW'(1));
               dump_left_in   = dump_left_ff - CW'(1);
               if (dump_left_ff == CW'(1)) begin
                  state_in = pol_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = pol_pkg::FSM_IDLE;
         end
      endcase
   end

   // Per-cell shift selects and neighbor wiring
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [pol_pkg::DATA_W-1:0] left_d;
      logic signed [pol_pkg::DATA_W-1:0] right_d;

      if (i == 0) begin : g_front
         assign left_d = req_value;
      end else begin : g_inner_l
         assign left_d = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_d = cell_q[i];
      end else begin : g_inner_r
         assign right_d = cell_q[i+1];
      end

      always_comb begin
         cell_op[i] = pol_pkg::CELL_HOLD;
         if (do_ins) begin
            if (IW'(i) == ins_idx) begin
               cell_op[i] = pol_pkg::CELL_LOAD;
            end else if (IW'(i) > ins_idx) begin
               cell_op[i] = pol_pkg::CELL_LEFT;
            end
         end else if (do_del) begin
            if (IW'(i) >= del_idx) begin
               cell_op[i] = pol_pkg::CELL_RIGHT;
            end
         end else if (do_rot) begin
            if (CW'(i) + CW'(1) == count_ff) begin
               cell_op[i] = pol_pkg::CELL_HEAD;
            end else if (CW'(i) + CW'(1) < count_ff) begin
               cell_op[i] = pol_pkg::CELL_RIGHT;
            end
         end
      end

      pol_cell u_cell (
         .clock   (clock),
         .op      (cell_op[i]),
         .new_d   (req_value),
         .left_d  (left_d),
         .right_d (right_d),
         .head_d  (cell_q[0]),
         .q       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pol_pkg::FSM_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

@@ rtl/pol_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one element, takes its
// neighbor's value on a shift. Depends on pol_pkg.
module pol_cell (
   input  logic                             clock,
   input  pol_pkg::pol_cell_op_type         op,
   input  logic signed [pol_pkg::DATA_W-1:0] new_d,
   input  logic signed [pol_pkg::DATA_W-1:0] left_d,
   input  logic signed [pol_pkg::DATA_W-1:0] right_d,
   input  logic signed [pol_pkg::DATA_W-1:0] head_d,
   output logic signed [pol_pkg::DATA_W-1:0] q
);

   logic signed [pol_pkg::DATA_W-1:0] data_ff;
   logic signed [pol_pkg::DATA_W-1:0] data_in;

   always_comb begin
      case (op)
         pol_pkg::CELL_LOAD:  data_in = new_d;
         pol_pkg::CELL_LEFT:  data_in = left_d;
         pol_pkg::CELL_RIGHT: data_in = right_d;
         pol_pkg::CELL_HEAD:  data_in = head_d;
         default:             data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

@@ test/pol_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the positional ordered list: tracks the list contents,
// predicts every result beat and compares the rsp channel against it.
// Depends on pol_pkg for command and status codes.
module pol_checker #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [4:0]                        req_position,
   input  logic signed [pol_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [2:0]                        rsp_status,
   input  logic signed [pol_pkg::DATA_W-1:0] rsp_element,
   input  logic [4:0]                        rsp_length,
   input  logic                              rsp_last,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                held_count
);

   typedef struct packed {
      logic [2:0]                        status;
      logic signed [pol_pkg::DATA_W-1:0] element;
      logic [4:0]                        length;
      logic                              last;
   } list_beat_type;

   logic signed [pol_pkg::DATA_W-1:0] list_contents[$];
   list_beat_type                     expected_beats[$];

   // length is taken after the edit, as the block reports it
   function automatic void queue_beat(input logic [2:0] status,
                                      input logic signed [pol_pkg::DATA_W-1:0] element,
                                      input logic last);
      list_beat_type b;
      b.status  = status;
      b.element = element;
      b.length  = 5'(list_contents.size());
      b.last    = last;
      expected_beats.push_back(b);
   endfunction

   function automatic void apply_list_command(input logic [2:0] cmd,
                                              input logic [4:0] pos,
                                              input logic signed [pol_pkg::DATA_W-1:0] val);
      int unsigned                       n;
      logic signed [pol_pkg::DATA_W-1:0] taken;
      n = list_contents.size();
      case (cmd)
         pol_pkg::CMD_INS_POS: begin
            // position 0 is rejected before the full check
            if (pos == 0) queue_beat(pol_pkg::ST_INVALID, '0, 1'b1);
            else if (n >= CAPACITY) queue_beat(pol_pkg::ST_FULL, '0, 1'b1);
            else if (n == 0) begin
               // empty list takes any nonzero position at the front
               list_contents.push_front(val);
               queue_beat(pol_pkg::ST_OK, '0, 1'b1);
            end else if (pos > n + 1) queue_beat(pol_pkg::ST_BOUND, '0, 1'b1);
            else begin
               list_contents.insert(pos - 1, val);
               queue_beat(pol_pkg::ST_OK, '0, 1'b1);
            end
         end
         pol_pkg::CMD_INS_END: begin
            if (n >= CAPACITY) queue_beat(pol_pkg::ST_FULL, '0, 1'b1);
            else begin
               list_contents.push_back(val);
               queue_beat(pol_pkg::ST_OK, '0, 1'b1);
            end
         end
         pol_pkg::CMD_DEL_POS: begin
            // empty wins over the position checks
            if (n == 0) queue_beat(pol_pkg::ST_EMPTY, '0, 1'b1);
            else if (pos == 0) queue_beat(pol_pkg::ST_INVALID, '0, 1'b1);
            else if (pos > n) queue_beat(pol_pkg::ST_BOUND, '0, 1'b1);
            else begin
               taken = list_contents[pos - 1];
               list_contents.delete(pos - 1);
               queue_beat(pol_pkg::ST_OK, taken, 1'b1);
            end
         end
         pol_pkg::CMD_DEL_END: begin
            if (n == 0) queue_beat(pol_pkg::ST_EMPTY, '0, 1'b1);
            else begin
               taken = list_contents.pop_back();
               queue_beat(pol_pkg::ST_OK, taken, 1'b1);
            end
         end
         pol_pkg::CMD_DUMP: begin
            if (n == 0) queue_beat(pol_pkg::ST_EMPTY, '0, 1'b1);
            else
               for (int i = 0; i < n; i++)
                  queue_beat(pol_pkg::ST_OK, list_contents[i], (i == n - 1));
         end
         default: ; // reserved codes: no beats, no change
      endcase
   endfunction

   function automatic void check_beat();
      list_beat_type want;
      if (expected_beats.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: unexpected rsp beat status=%0d element=%0d length=%0d last=%0b",
                     $time, rsp_status, rsp_element, rsp_length, rsp_last);
         return;
      end
      want = expected_beats.pop_front();
      if (rsp_status !== want.status || rsp_element !== want.element ||
          rsp_length !== want.length || rsp_last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: rsp mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     $time, want.status, want.element, want.length, want.last,
                     rsp_status, rsp_element, rsp_length, rsp_last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_contents.delete();
         expected_beats.delete();
      end else begin
         // a result beat never comes from the request taken on the same edge
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready)
            apply_list_command(req_cmd, req_position, req_value);
      end
      pending_count <= expected_beats.size();
      held_count    <= list_contents.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the positional ordered list test: clock, reset, command stimulus,
// result-side back-pressure and the verdict.
// Depends on pol_pkg, positional_ordered_list and pol_checker.
module tb;

   localparam int unsigned CAPACITY     = 16;
   localparam int unsigned RANDOM_ITEMS = 100;
   localparam int unsigned LONG_HOLD    = 120;   // cycles of rsp_ready low
   localparam int unsigned DRAIN_CYCLES = 20;

   // command codes the block ignores
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   logic                              clock        = 1'b0;
   logic                              reset        = 1'b1;
   logic                              req_valid    = 1'b0;
   logic                              req_ready;
   logic [2:0]                        req_cmd      = '0;
   logic [4:0]                        req_position = '0;
   logic signed [pol_pkg::DATA_W-1:0] req_value    = '0;
   logic                              rsp_valid;
   logic                              rsp_ready    = 1'b0;
   logic [2:0]                        rsp_status;
   logic signed [pol_pkg::DATA_W-1:0] rsp_element;
   logic [4:0]                        rsp_length;
   logic                              rsp_last;

   int mismatch_count;
   int pending_count;
   int held_count;

   // set by the stimulus; hold_request is read by the result-side process
   bit steady       = 1'b0;   // sender offers back to back
   bit hold_request = 1'b0;   // ask the result side for one long hold-off

   always #10 clock = ~clock;

   positional_ordered_list #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

   pol_checker #(
      .CAPACITY (CAPACITY)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_element    (rsp_element),
      .rsp_length     (rsp_length),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .held_count     (held_count)
   );

   // Values: the two's complement extremes, zero and -1 show up often,
   // the rest is full-width random so every bit toggles.
   function automatic logic signed [pol_pkg::DATA_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // One request beat. Valid goes up after the drawn gap and stays up until
   // the edge where req_ready is seen high. The caller must issue the next
   // beat (or drop valid) in the same time step, so the accepted beat is
   // never offered twice.
   task automatic send_beat(input logic [2:0] cmd, input logic [4:0] pos,
                            input logic signed [pol_pkg::DATA_W-1:0] val);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Result side: a stall drawn at random before each beat, with stretches of none.
   // Once, on request, a long hold-off so the output stage fills and the
   // block drops req_ready while the sender keeps offering.
   initial begin : rsp_side
      int unsigned gap;
      int unsigned beats;
      bit          rx_steady;
      bit          hold_done;
      beats     = 0;
      rx_steady = 1'b0;
      hold_done = 1'b0;
      forever begin
         if (hold_request && !hold_done) begin
            gap       = LONG_HOLD;
            hold_done = 1'b1;
         end else if (rx_steady) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 4);
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats++;
         if (beats % 24 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      end
   end

   // Main stimulus: reset, directed corner cases, then random episodes.
   initial begin : stimulus
      int unsigned random_sent;
      int unsigned n;
      int unsigned kind;
      int unsigned pick;
      bit          first_episode;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // everything that needs a non-empty list, tried on an empty one
      send_beat(pol_pkg::CMD_DUMP,    5'd0,  '0);
      send_beat(pol_pkg::CMD_DEL_END, 5'd0,  '0);
      send_beat(pol_pkg::CMD_DEL_POS, 5'd1,  '0);
      send_beat(pol_pkg::CMD_DEL_POS, 5'd0,  '0);        // empty beats position zero
      send_beat(pol_pkg::CMD_INS_POS, 5'd0,  32'sd5);    // position zero on insert
      send_beat(pol_pkg::CMD_INS_POS, 5'd31, 32'sh7FFF_FFFF); // empty: lands at front
      send_beat(pol_pkg::CMD_INS_POS, 5'd5,  32'sd1);    // past end + 1 -> out of bound
      send_beat(pol_pkg::CMD_INS_POS, 5'd2,  32'sh8000_0000); // exactly end + 1: append
      send_beat(pol_pkg::CMD_INS_POS, 5'd1,  -32'sd1);   // front
      send_beat(pol_pkg::CMD_INS_END, 5'd17, '0);
      send_beat(pol_pkg::CMD_DUMP,    5'd31, '1);
      send_beat(pol_pkg::CMD_DEL_POS, 5'd0,  '0);
      send_beat(pol_pkg::CMD_DEL_POS, 5'd5,  '0);        // one past the end
      send_beat(pol_pkg::CMD_DEL_POS, 5'd2,  '0);
      send_beat(pol_pkg::CMD_DEL_END, 5'd0,  '0);
      // reserved codes must be swallowed without a beat
      for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
         send_beat(3'(c), 5'(c), draw_value());
      send_beat(pol_pkg::CMD_INS_POS, 5'd16, 32'sd42);   // out of bound on short list
      send_beat(pol_pkg::CMD_DUMP,    5'd0,  '0);

      // --- random episodes ---
      // Fill runs push the list to full and beyond, drain runs empty it and
      // keep going, mixed runs throw in everything including noise. The
      // first fill also triggers the long result-side hold-off.
      random_sent   = 0;
      first_episode = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         kind   = first_episode ? 0 : $urandom_range(0, 3);
         steady = first_episode ? 1'b1 : ($urandom_range(0, 3) == 0);
         if (first_episode) hold_request = 1'b1;
         first_episode = 1'b0;
         case (kind)
            0: begin
               n = CAPACITY + 3 - held_count;
               repeat (n) begin
                  if ($urandom_range(0, 1))
                     send_beat(pol_pkg::CMD_INS_POS,
                               5'($urandom_range(1, held_count + 1)), draw_value());
                  else
                     send_beat(pol_pkg::CMD_INS_END, 5'($urandom_range(0, 31)),
                               draw_value());
               end
               send_beat(pol_pkg::CMD_DUMP, 5'($urandom_range(0, 31)), draw_value());
               random_sent += n + 1;
            end
            1: begin
               n = held_count + 2;
               repeat (n) begin
                  if ($urandom_range(0, 1))
                     send_beat(pol_pkg::CMD_DEL_POS,
                               5'($urandom_range(1, (held_count == 0) ? 1 : held_count)),
                               draw_value());
                  else
                     send_beat(pol_pkg::CMD_DEL_END, 5'($urandom_range(0, 31)),
                               draw_value());
               end
               send_beat(pol_pkg::CMD_DUMP, 5'($urandom_range(0, 31)), draw_value());
               random_sent += n + 1;
            end
            default: begin
               repeat (12) begin
                  pick = $urandom_range(0, 19);
                  if (pick <= 4)
                     send_beat(pol_pkg::CMD_INS_POS,
                               5'($urandom_range(1, held_count + 1)), draw_value());
                  else if (pick <= 7)
                     send_beat(pol_pkg::CMD_INS_END, 5'($urandom), draw_value());
                  else if (pick <= 10)
                     send_beat(pol_pkg::CMD_DEL_POS,
                               5'($urandom_range(1, (held_count == 0) ? 1 : held_count)),
                               draw_value());
                  else if (pick <= 12)
                     send_beat(pol_pkg::CMD_DEL_END, 5'($urandom), draw_value());
                  else if (pick <= 14)
                     send_beat(pol_pkg::CMD_DUMP, 5'($urandom), draw_value());
                  else if (pick <= 16)
                     // any position at all, mostly out of range
                     send_beat(pol_pkg::CMD_INS_POS, 5'($urandom), draw_value());
                  else if (pick == 17)
                     send_beat(pol_pkg::CMD_DEL_POS, 5'($urandom), draw_value());
                  else if (pick == 18)
                     send_beat(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                               5'($urandom), draw_value());
                  else
                     send_beat(pol_pkg::CMD_DEL_POS, 5'd0, draw_value());
               end
               random_sent += 12;
            end
         endcase
      end
      req_valid <= 1'b0;

      // let the scoreboard see the last request, then drain all results
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("positional_ordered_list test passed");
      else
         $display("positional_ordered_list test failed");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #3_000_000;
      $display("positional_ordered_list test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
test/pol_checker.sv
test/tb.sv
